// ===== hdl/msp_v1_v2_frame_parser_assert.svh =====
// assertion helpers for the msp frame parser
`ifndef MSP_V1_V2_FRAME_PARSER_ASSERT_SVH
`define MSP_V1_V2_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MSPFP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MSPFP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mspfp_pkg.sv =====
package mspfp_pkg;

    localparam int unsigned DEF_MAX_PAYLOAD = 256;
    localparam logic [15:0] DEF_IDLE_TIMEOUT = 16'd1000;

    // framing characters, jumbo length marker and crc polynomial
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_V1      = 8'h4D;
    localparam logic [7:0] CH_V2      = 8'h58;
    localparam logic [7:0] CH_DIR_IN  = 8'h3C;
    localparam logic [7:0] JUMBO_LEN  = 8'hFF;
    localparam logic [7:0] CRC_POLY   = 8'hD5;

    // op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // protocol versions
    localparam logic [1:0] VER_NONE = 2'd0;
    localparam logic [1:0] VER_V1   = 2'd1;
    localparam logic [1:0] VER_V2   = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_PROTO    = 4'd1,
        PH_DIR      = 4'd2,
        PH_FLAG2    = 4'd3,
        PH_LEN1     = 4'd4,
        PH_CODE1    = 4'd5,
        PH_CODEJ    = 4'd6,
        PH_JLEN_LO  = 4'd7,
        PH_JLEN_HI  = 4'd8,
        PH_CODE2_LO = 4'd9,
        PH_CODE2_HI = 4'd10,
        PH_LEN2_LO  = 4'd11,
        PH_LEN2_HI  = 4'd12,
        PH_PAYLOAD  = 4'd13,
        PH_CHECK    = 4'd14
    } t_phase;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic        consumed;
        logic        msp_mode;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        frame_ok;
        logic        checksum_error;
        logic        overflow_error;
        logic [15:0] command_id;
        logic [15:0] payload_length;
        logic [1:0]  protocol_version;
        logic [7:0]  v2_flags;
    } t_out_word;

    // crc-8 dvb-s2, one byte, msb first
    function automatic logic [7:0] crc8_dvb_s2(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/mspfp_core.sv =====
module mspfp_core #(
    parameter int unsigned MAX_PAYLOAD = mspfp_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  mspfp_pkg::t_in_word  i_word,
    input  logic [15:0]          i_idle_timeout,
    output mspfp_pkg::t_out_word o_result
);

    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

    mspfp_pkg::t_phase r_phase, n_phase;
    logic [7:0]        r_check, n_check;
    logic [15:0]       r_cmd, n_cmd;
    logic [15:0]       r_exp_len, n_exp_len;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [1:0]        r_ver, n_ver;
    logic [7:0]        r_flag, n_flag;
    logic              r_mode, n_mode;
    logic [15:0]       r_idle_cnt, n_idle_cnt;

    logic [7:0]        b;
    logic [7:0]        fold_val;
    logic [15:0]       idle_inc;
    logic              tick_timeout;
    logic [CNT_W-1:0]  count_inc;
    logic [15:0]       count_ext;
    logic              buf_full;
    logic              last_payload;
    logic [15:0]       len_hi_word;

    assign b            = i_word.data_byte;
    assign fold_val     = (r_ver == mspfp_pkg::VER_V1) ? (r_check ^ b)
                                                       : mspfp_pkg::crc8_dvb_s2(r_check, b);
    assign idle_inc     = (r_idle_cnt == 16'hFFFF) ? r_idle_cnt : r_idle_cnt + 16'd1;
    assign tick_timeout = r_mode && (idle_inc > i_idle_timeout);
    assign count_inc    = r_count + CNT_W'(1);
    assign count_ext    = 16'(r_count);
    assign buf_full     = (r_count >= CNT_W'(MAX_PAYLOAD));
    assign last_payload = (16'(count_inc) >= r_exp_len);
    assign len_hi_word  = {b, r_exp_len[7:0]};

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_word.op == mspfp_pkg::OP_TICK) begin
            if (tick_timeout) begin
                n_phase = mspfp_pkg::PH_IDLE;
            end
        end else begin
            unique case (r_phase)
                mspfp_pkg::PH_IDLE: begin
                    n_phase = (b == mspfp_pkg::CH_DOLLAR) ? mspfp_pkg::PH_PROTO
                                                          : mspfp_pkg::PH_IDLE;
                end
                mspfp_pkg::PH_PROTO: begin
                    n_phase = (b == mspfp_pkg::CH_V1 || b == mspfp_pkg::CH_V2)
                              ? mspfp_pkg::PH_DIR : mspfp_pkg::PH_IDLE;
                end
                mspfp_pkg::PH_DIR: begin
                    if (b != mspfp_pkg::CH_DIR_IN) begin
                        n_phase = mspfp_pkg::PH_IDLE;
                    end else if (r_ver == mspfp_pkg::VER_V1) begin
                        n_phase = mspfp_pkg::PH_LEN1;
                    end else begin
                        n_phase = mspfp_pkg::PH_FLAG2;
                    end
                end
                mspfp_pkg::PH_FLAG2:    n_phase = mspfp_pkg::PH_CODE2_LO;
                mspfp_pkg::PH_LEN1: begin
                    n_phase = (b == mspfp_pkg::JUMBO_LEN) ? mspfp_pkg::PH_CODEJ
                                                          : mspfp_pkg::PH_CODE1;
                end
                mspfp_pkg::PH_CODE1: begin
                    n_phase = (r_exp_len != 16'd0) ? mspfp_pkg::PH_PAYLOAD
                                                   : mspfp_pkg::PH_CHECK;
                end
                mspfp_pkg::PH_CODEJ:    n_phase = mspfp_pkg::PH_JLEN_LO;
                mspfp_pkg::PH_JLEN_LO:  n_phase = mspfp_pkg::PH_JLEN_HI;
                mspfp_pkg::PH_CODE2_LO: n_phase = mspfp_pkg::PH_CODE2_HI;
                mspfp_pkg::PH_CODE2_HI: n_phase = mspfp_pkg::PH_LEN2_LO;
                mspfp_pkg::PH_LEN2_LO:  n_phase = mspfp_pkg::PH_LEN2_HI;
                mspfp_pkg::PH_JLEN_HI,
                mspfp_pkg::PH_LEN2_HI: begin
                    n_phase = (len_hi_word != 16'd0) ? mspfp_pkg::PH_PAYLOAD
                                                     : mspfp_pkg::PH_CHECK;
                end
                mspfp_pkg::PH_PAYLOAD: begin
                    if (buf_full) begin
                        n_phase = mspfp_pkg::PH_IDLE;
                    end else if (last_payload) begin
                        n_phase = mspfp_pkg::PH_CHECK;
                    end
                end
                mspfp_pkg::PH_CHECK:    n_phase = mspfp_pkg::PH_IDLE;
                default:                n_phase = mspfp_pkg::PH_IDLE;
            endcase
        end
    end

    // frame registers and result word
    always_comb begin
        logic report;
        report     = 1'b0;
        n_check    = r_check;
        n_cmd      = r_cmd;
        n_exp_len  = r_exp_len;
        n_count    = r_count;
        n_ver      = r_ver;
        n_flag     = r_flag;
        n_mode     = r_mode;
        n_idle_cnt = r_idle_cnt;
        o_result   = '0;

        if (i_word.op == mspfp_pkg::OP_TICK) begin
            n_idle_cnt = idle_inc;
            if (tick_timeout) begin
                n_mode = 1'b0;
            end
        end else begin
            n_idle_cnt        = '0;
            o_result.consumed = 1'b1;
            unique case (r_phase)
                mspfp_pkg::PH_IDLE: begin
                    n_check   = '0;
                    n_cmd     = '0;
                    n_exp_len = '0;
                    n_count   = '0;
                    n_ver     = mspfp_pkg::VER_NONE;
                    n_flag    = '0;
                    o_result.consumed = (b == mspfp_pkg::CH_DOLLAR);
                end
                mspfp_pkg::PH_PROTO: begin
                    n_check = '0;
                    if (b == mspfp_pkg::CH_V1) begin
                        n_ver = mspfp_pkg::VER_V1;
                    end else if (b == mspfp_pkg::CH_V2) begin
                        n_ver = mspfp_pkg::VER_V2;
                    end else begin
                        o_result.consumed = 1'b0;
                    end
                end
                mspfp_pkg::PH_DIR: begin
                    if (b == mspfp_pkg::CH_DIR_IN) begin
                        n_mode = 1'b1;
                    end else begin
                        o_result.consumed = 1'b0;
                    end
                end
                mspfp_pkg::PH_FLAG2: begin
                    n_flag  = b;
                    n_check = fold_val;
                end
                mspfp_pkg::PH_LEN1,
                mspfp_pkg::PH_JLEN_LO,
                mspfp_pkg::PH_LEN2_LO: begin
                    n_exp_len = {8'h00, b};
                    n_check   = fold_val;
                end
                mspfp_pkg::PH_CODE1: begin
                    n_cmd   = {8'h00, b};
                    n_check = fold_val;
                    n_count = '0;
                end
                mspfp_pkg::PH_CODEJ,
                mspfp_pkg::PH_CODE2_LO: begin
                    n_cmd   = {8'h00, b};
                    n_check = fold_val;
                end
                mspfp_pkg::PH_CODE2_HI: begin
                    n_cmd   = {b, r_cmd[7:0]};
                    n_check = fold_val;
                end
                mspfp_pkg::PH_JLEN_HI,
                mspfp_pkg::PH_LEN2_HI: begin
                    n_exp_len = len_hi_word;
                    n_check   = fold_val;
                    n_count   = '0;
                end
                mspfp_pkg::PH_PAYLOAD: begin
                    if (buf_full) begin
                        o_result.overflow_error = 1'b1;
                        report = 1'b1;
                    end else begin
                        o_result.payload_valid = 1'b1;
                        o_result.payload_byte  = b;
                        o_result.payload_index = count_ext[7:0];
                        n_count = count_inc;
                        n_check = fold_val;
                    end
                end
                mspfp_pkg::PH_CHECK: begin
                    o_result.frame_ok       = (r_check == b);
                    o_result.checksum_error = (r_check != b);
                    report = 1'b1;
                end
                default: begin
                end
            endcase
            if (report) begin
                o_result.command_id       = r_cmd;
                o_result.payload_length   = count_ext;
                o_result.protocol_version = r_ver;
                o_result.v2_flags         = r_flag;
            end
        end
        o_result.msp_mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= mspfp_pkg::PH_IDLE;
            r_check    <= '0;
            r_cmd      <= '0;
            r_exp_len  <= '0;
            r_count    <= '0;
            r_ver      <= mspfp_pkg::VER_NONE;
            r_flag     <= '0;
            r_mode     <= 1'b0;
            r_idle_cnt <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_check    <= n_check;
            r_cmd      <= n_cmd;
            r_exp_len  <= n_exp_len;
            r_count    <= n_count;
            r_ver      <= n_ver;
            r_flag     <= n_flag;
            r_mode     <= n_mode;
            r_idle_cnt <= n_idle_cnt;
        end
    end

endmodule

// ===== hdl/msp_v1_v2_frame_parser.sv =====
// msp v1/v2 receive frame parser
//
// input channel: one word per received serial byte (op = byte) or per time
// tick (op = tick), handshake i_in_valid / o_in_stall
// output channel: exactly one result word per input word, in order,
// handshake o_out_valid / i_out_stall
// config: i_cfg_we writes i_cfg_wdata into the idle timeout (ticks), write
// only while the parser is idle; reset value is 1000
//
// an accepted word passes through the input register, then the result register, on
// its way to the output; throughput is one word per cycle while the receiver does not stall
// the parse itself is one state step per word, the crc-8 update is unrolled
// xor logic between the input and result registers
//
// reset (synchronous, active low) empties both registers, puts the parser
// in idle, terminal mode, zero idle count and restores the default timeout
// when the receiver stalls, the result register holds its word and one more
// input word is still taken into the input register; after that o_in_stall
// rises until the result is taken
`include "msp_v1_v2_frame_parser_assert.svh"

module msp_v1_v2_frame_parser #(
    parameter int unsigned MAX_PAYLOAD = mspfp_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mspfp_pkg::t_in_word  i_in_word,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mspfp_pkg::t_out_word o_out_word,
    // idle timeout register
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata
);

    // input stage
    logic                 r_in_valid;
    mspfp_pkg::t_in_word  r_in_word;
    // result stage
    logic                 r_out_valid;
    mspfp_pkg::t_out_word r_out_word;
    // config
    logic [15:0]          r_idle_timeout;

    logic                 in_accept;
    logic                 step;     // input word moves through the parser
    mspfp_pkg::t_out_word result;

    // an input word is waiting and the result slot is free or being emptied this cycle
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    // stall only when both stages are full and the output is held
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    mspfp_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_word         (r_in_word),
        .i_idle_timeout (r_idle_timeout),
        .o_result       (result)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_idle_timeout <= mspfp_pkg::DEF_IDLE_TIMEOUT;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_idle_timeout <= i_cfg_wdata;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_in_word;
        end
        if (step) begin
            r_out_word <= result;
        end
    end

    // a frame report always carries a known protocol version
    `MSPFP_ASSERT_IMP(a_report_version, i_clk, i_rst_n,
        r_out_valid && (r_out_word.frame_ok || r_out_word.checksum_error ||
        r_out_word.overflow_error),
        r_out_word.protocol_version == mspfp_pkg::VER_V1 ||
        r_out_word.protocol_version == mspfp_pkg::VER_V2,
        "frame report without protocol version")
    // a payload byte never coincides with a frame report
    `MSPFP_ASSERT_IMP(a_payload_no_report, i_clk, i_rst_n,
        r_out_valid && r_out_word.payload_valid,
        !r_out_word.frame_ok && !r_out_word.checksum_error && !r_out_word.overflow_error,
        "payload byte flagged together with frame report")
    // a good frame is only seen in msp mode
    `MSPFP_ASSERT_IMP(a_ok_in_msp_mode, i_clk, i_rst_n,
        r_out_valid && r_out_word.frame_ok,
        r_out_word.msp_mode && r_out_word.consumed,
        "frame ok outside msp mode")
    // every word moved through the parser yields a result word
    `MSPFP_ASSERT_NXT(a_step_fills_result, i_clk, i_rst_n,
        step,
        r_out_valid,
        "parser step lost its result")

endmodule

// ===== sim/msp_result_checker.sv =====
`timescale 1ns / 100ps

module msp_result_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  mspfp_pkg::t_in_word  i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  mspfp_pkg::t_out_word i_out_word,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata,
    output int                   o_pending,
    output int                   o_fail_count
);
    import mspfp_pkg::*;

    localparam int unsigned PAYLOAD_CAP = DEF_MAX_PAYLOAD;
    localparam int unsigned REPORT_LIMIT = 10;

    // parser mirror
    t_phase      ph;
    logic [7:0]  chk_acc;
    logic [15:0] cmd_acc;
    logic [15:0] len_decl;
    logic [8:0]  rx_count;
    logic [1:0]  ver;
    logic [7:0]  flags;
    logic        in_msp;
    logic [15:0] idle_ticks;
    logic [15:0] timeout_ticks;

    t_out_word   predicted_words[$];
    int          fail_total = 0;

    assign o_fail_count = fail_total;

    // bit-serial crc-8, poly 0xd5, msb first
    function automatic logic [7:0] crc8_serial(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic void fold_check(input logic [7:0] b);
        if (ver == VER_V1) begin
            chk_acc = chk_acc ^ b;
        end else begin
            chk_acc = crc8_serial(chk_acc, b);
        end
    endfunction

    function automatic void clear_frame();
        chk_acc = 8'h00;
        cmd_acc = 16'h0000;
        len_decl = 16'h0000;
        rx_count = 9'd0;
        ver = VER_NONE;
        flags = 8'h00;
    endfunction

    function automatic void reset_parser();
        clear_frame();
        ph = PH_IDLE;
        in_msp = 1'b0;
        idle_ticks = 16'h0000;
        timeout_ticks = DEF_IDLE_TIMEOUT;
    endfunction

    // one parser step, returns the result word it causes
    function automatic t_out_word parse_step(input t_in_word w);
        t_out_word  r;
        logic [7:0] b;
        logic       report;
        r = '0;
        b = w.data_byte;
        report = 1'b0;
        if (w.op == OP_TICK) begin
            if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
            if (in_msp && idle_ticks > timeout_ticks) begin
                in_msp = 1'b0;
                ph = PH_IDLE;
            end
        end else begin
            idle_ticks = 16'h0000;
            r.consumed = 1'b1;
            case (ph)
                PH_IDLE: begin
                    clear_frame();
                    if (b == CH_DOLLAR) ph = PH_PROTO;
                    else r.consumed = 1'b0;
                end
                PH_PROTO: begin
                    chk_acc = 8'h00;
                    if (b == CH_V1) begin
                        ver = VER_V1;
                        ph = PH_DIR;
                    end else if (b == CH_V2) begin
                        ver = VER_V2;
                        ph = PH_DIR;
                    end else begin
                        ph = PH_IDLE;
                        r.consumed = 1'b0;
                    end
                end
                PH_DIR: begin
                    if (b == CH_DIR_IN) begin
                        in_msp = 1'b1;
                        if (ver == VER_V1) ph = PH_LEN1;
                        else ph = PH_FLAG2;
                    end else begin
                        ph = PH_IDLE;
                        r.consumed = 1'b0;
                    end
                end
                PH_FLAG2: begin
                    flags = b;
                    fold_check(b);
                    ph = PH_CODE2_LO;
                end
                PH_LEN1: begin
                    len_decl = {8'h00, b};
                    fold_check(b);
                    if (b == JUMBO_LEN) ph = PH_CODEJ;
                    else ph = PH_CODE1;
                end
                PH_CODE1: begin
                    cmd_acc = {8'h00, b};
                    fold_check(b);
                    rx_count = 9'd0;
                    if (len_decl != 16'd0) ph = PH_PAYLOAD;
                    else ph = PH_CHECK;
                end
                PH_CODEJ: begin
                    cmd_acc = {8'h00, b};
                    fold_check(b);
                    ph = PH_JLEN_LO;
                end
                PH_JLEN_LO, PH_LEN2_LO: begin
                    len_decl = {8'h00, b};
                    fold_check(b);
                    if (ph == PH_JLEN_LO) ph = PH_JLEN_HI;
                    else ph = PH_LEN2_HI;
                end
                PH_JLEN_HI, PH_LEN2_HI: begin
                    len_decl = {b, len_decl[7:0]};
                    fold_check(b);
                    rx_count = 9'd0;
                    if (len_decl != 16'd0) ph = PH_PAYLOAD;
                    else ph = PH_CHECK;
                end
                PH_CODE2_LO: begin
                    cmd_acc = {8'h00, b};
                    fold_check(b);
                    ph = PH_CODE2_HI;
                end
                PH_CODE2_HI: begin
                    cmd_acc = {b, cmd_acc[7:0]};
                    fold_check(b);
                    ph = PH_LEN2_LO;
                end
                PH_PAYLOAD: begin
                    if (rx_count >= PAYLOAD_CAP) begin
                        r.overflow_error = 1'b1;
                        report = 1'b1;
                        ph = PH_IDLE;
                    end else begin
                        r.payload_valid = 1'b1;
                        r.payload_byte = b;
                        r.payload_index = rx_count[7:0];
                        rx_count = rx_count + 9'd1;
                        fold_check(b);
                        if (rx_count >= len_decl) ph = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    if (chk_acc == b) r.frame_ok = 1'b1;
                    else r.checksum_error = 1'b1;
                    report = 1'b1;
                    ph = PH_IDLE;
                end
                default: ph = PH_IDLE;
            endcase
            if (report) begin
                r.command_id = cmd_acc;
                r.payload_length = {7'd0, rx_count};
                r.protocol_version = ver;
                r.v2_flags = flags;
            end
        end
        r.msp_mode = in_msp;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
                $display("mismatch %s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        end
    endfunction

    function automatic void compare_word(input t_out_word act);
        t_out_word exp_w;
        if (predicted_words.size() == 0) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
                $display("mismatch: result word 0x%0h with none expected", act);
        end else begin
            exp_w = predicted_words.pop_front();
            check_field("consumed", exp_w.consumed, act.consumed);
            check_field("msp_mode", exp_w.msp_mode, act.msp_mode);
            check_field("payload_valid", exp_w.payload_valid, act.payload_valid);
            check_field("payload_byte", exp_w.payload_byte, act.payload_byte);
            check_field("payload_index", exp_w.payload_index, act.payload_index);
            check_field("frame_ok", exp_w.frame_ok, act.frame_ok);
            check_field("checksum_error", exp_w.checksum_error, act.checksum_error);
            check_field("overflow_error", exp_w.overflow_error, act.overflow_error);
            check_field("command_id", exp_w.command_id, act.command_id);
            check_field("payload_length", exp_w.payload_length, act.payload_length);
            check_field("protocol_version", exp_w.protocol_version, act.protocol_version);
            check_field("v2_flags", exp_w.v2_flags, act.v2_flags);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_parser();
            predicted_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) compare_word(i_out_word);
            if (i_cfg_we) timeout_ticks = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) predicted_words.push_back(parse_step(i_in_word));
        end
        o_pending <= predicted_words.size();
    end

endmodule

// ===== sim/msp_v1_v2_frame_parser_test.sv =====
`timescale 1ns / 100ps

module msp_v1_v2_frame_parser_test;
    import mspfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int unsigned RANDOM_PHASES = 3;
    localparam int unsigned RANDOM_WORDS  = 140;   // words per random phase
    localparam int unsigned LONG_TICKS    = 40;    // tick run under the largest timeout
    localparam int unsigned PAYLOAD_CAP   = DEF_MAX_PAYLOAD;
    localparam logic [7:0]  CH_DIR_OUT    = 8'h3E; // outgoing direction, rejected

    typedef enum logic [1:0] {
        FK_V1,
        FK_JUMBO,
        FK_V2
    } t_frame_kind;

    // clock, reset and block ports; the ones driven here are known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_word    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    int          pending;
    int          fail_count;
    int unsigned cycle_count = 0;
    int unsigned words_sent = 0;

    // shared pacing controls: quiet turns off idling on both sides,
    // hold_req asks the receiver for one long hold-off
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    logic [15:0] cur_timeout = DEF_IDLE_TIMEOUT;

    always #10 i_clk = ~i_clk;

    msp_v1_v2_frame_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    msp_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // random idle gap before the next word or result word, none while quiet
    function automatic int unsigned pick_wait();
        if (quiet) return 0;
        return $urandom_range(0, 16);
    endfunction

    // byte-wise crc-8 dvb-s2, only used to build frame checksums
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    // receiver: random stall before each result word, or one long hold-off
    // on request while the sender keeps offering words
    initial begin
        int unsigned n;
        forever begin
            if (hold_req) begin
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                n = pick_wait();
            end
            if (n != 0) begin
                out_stall <= 1'b1;
                for (int i = 0; i < n; i++) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    // offer one word after a random gap, return at the edge that takes it
    task automatic send_word(input logic op, input logic [7:0] b);
        int unsigned gap;
        gap = pick_wait();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= t_in_word'({op, b});
        do @(posedge i_clk); while (in_stall);
        words_sent++;
    endtask

    // stop offering and wait until every predicted result word is back,
    // then let the two-stage pipeline settle
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // timeout register is only written with the parser pipeline empty
    task automatic write_timeout(input logic [15:0] v);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        cur_timeout = v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // one incoming frame with random payload; declared lengths past the
    // payload cap stop at the byte that overflows, with no checksum byte
    task automatic send_frame(input t_frame_kind kind, input logic [15:0] len,
                              input logic [15:0] cmd, input logic [7:0] flag,
                              input bit corrupt, input bit tick_gaps);
        logic [7:0]  body[$];
        logic [7:0]  acc;
        int unsigned n_pay;
        acc = 8'h00;
        case (kind)
            FK_V1:    body = '{len[7:0], cmd[7:0]};
            FK_JUMBO: body = '{JUMBO_LEN, cmd[7:0], len[7:0], len[15:8]};
            default:  body = '{flag, cmd[7:0], cmd[15:8], len[7:0], len[15:8]};
        endcase
        n_pay = (len > PAYLOAD_CAP) ? PAYLOAD_CAP + 1 : len;
        repeat (n_pay) body.push_back(8'($urandom));
        foreach (body[i]) acc = (kind == FK_V2) ? crc8_step(acc, body[i]) : acc ^ body[i];
        send_word(OP_BYTE, CH_DOLLAR);
        send_word(OP_BYTE, (kind == FK_V2) ? CH_V2 : CH_V1);
        send_word(OP_BYTE, CH_DIR_IN);
        foreach (body[i]) begin
            // a lone tick between bytes never reaches the timeout
            if (tick_gaps && $urandom_range(0, 7) == 0) send_word(OP_TICK, 8'($urandom));
            send_word(OP_BYTE, body[i]);
        end
        if (len <= PAYLOAD_CAP)
            send_word(OP_BYTE, corrupt ? acc ^ (8'h01 << $urandom_range(0, 7)) : acc);
    endtask

    // one random chunk: mostly good frames, some broken headers,
    // tick runs around the timeout and stray bytes
    task automatic random_chunk();
        int unsigned pick;
        int unsigned n;
        t_frame_kind kind;
        logic [15:0] len;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            case ($urandom_range(0, 2))
                0:       kind = FK_V1;
                1:       kind = FK_JUMBO;
                default: kind = FK_V2;
            endcase
            // rare long frame, often past the payload cap
            if (kind != FK_V1 && $urandom_range(0, 39) == 0)
                len = 16'($urandom_range(250, 300));
            else
                len = 16'($urandom_range(0, 8));
            send_frame(kind, len, 16'($urandom), 8'($urandom),
                       $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
        end else if (pick < 75) begin
            // header cut short or wrong
            send_word(OP_BYTE, CH_DOLLAR);
            case ($urandom_range(0, 2))
                0:       b = CH_V1;
                1:       b = CH_V2;
                default: b = 8'($urandom);
            endcase
            send_word(OP_BYTE, b);
            if (b == CH_V1 || b == CH_V2)
                send_word(OP_BYTE, $urandom_range(0, 1) ? CH_DIR_OUT : 8'($urandom));
        end else if (pick < 90) begin
            n = $urandom_range(1, cur_timeout + 3);
            repeat (n) send_word(OP_TICK, 8'($urandom));
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_word(OP_BYTE, 8'($urandom));
        end
    endtask

    initial begin
        int unsigned phase_start;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with the reset timeout
        // tick and stray byte in terminal mode
        send_word(OP_TICK, 8'hFF);
        send_word(OP_BYTE, 8'h00);
        // zero-length v1 frame
        send_frame(FK_V1, 16'd0, 16'h00FF, 8'h00, 1'b0, 1'b0);
        // v2 frame with all-ones flags and command
        send_frame(FK_V2, 16'd1, 16'hFFFF, 8'hFF, 1'b0, 1'b0);
        // bad protocol byte, then bad direction byte
        send_word(OP_BYTE, CH_DOLLAR);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, CH_DOLLAR);
        send_word(OP_BYTE, CH_V2);
        send_word(OP_BYTE, CH_DIR_OUT);
        // zero-length jumbo frame with a bad checksum
        send_frame(FK_JUMBO, 16'd0, 16'h0000, 8'h00, 1'b1, 1'b0);

        // shortest timeout: two ticks end msp mode, also mid-frame
        write_timeout(16'd1);
        send_word(OP_BYTE, CH_DOLLAR);
        send_word(OP_BYTE, CH_V1);
        send_word(OP_BYTE, CH_DIR_IN);
        send_word(OP_TICK, 8'h00);
        send_word(OP_TICK, 8'h00);
        send_word(OP_BYTE, CH_DOLLAR);
        send_word(OP_BYTE, CH_V2);
        send_word(OP_BYTE, CH_DIR_IN);
        send_word(OP_BYTE, 8'h5A);
        send_word(OP_TICK, 8'h00);
        send_word(OP_TICK, 8'h00);
        send_frame(FK_V1, 16'd3, 16'h0042, 8'h00, 1'b0, 1'b1);

        // full payload, then overflow at the largest declared length
        write_timeout(16'd20);
        send_frame(FK_V2, 16'd256, 16'($urandom), 8'($urandom), 1'b0, 1'b0);
        send_frame(FK_JUMBO, 16'hFFFF, 16'($urandom), 8'h00, 1'b0, 1'b0);

        // random phases, each with its own timeout; the second one starts
        // with a long receiver hold-off so the block backs up
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_timeout(16'($urandom_range(1, 40)));
            if (p == 1) hold_req = 1'b1;
            phase_start = words_sent;
            while (words_sent - phase_start < RANDOM_WORDS) begin
                quiet = ($urandom_range(0, 7) == 0);
                random_chunk();
            end
            quiet = 1'b0;
        end

        // largest timeout: msp mode holds over a run of ticks
        write_timeout(16'hFFFF);
        quiet = 1'b1;
        send_word(OP_BYTE, CH_DOLLAR);
        send_word(OP_BYTE, CH_V1);
        send_word(OP_BYTE, CH_DIR_IN);
        repeat (LONG_TICKS) send_word(OP_TICK, 8'($urandom));
        quiet = 1'b0;

        drain_results();
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
